// ===== rtl/lfr_pkg.sv =====
`timescale 1ns / 1ps

package lfr_pkg;

  // default payload limit (destuffed bytes, check byte included)
  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_KIND       = 3'd0,
    REG_ROLE             = 3'd1,
    REG_SEQUENCE_PARITY  = 3'd2,
    REG_FLAG_BYTE        = 3'd3,
    REG_ESCAPE_BYTE      = 3'd4,
    REG_STUFF_MASK       = 3'd5,
    REG_SENDER_ADDRESS   = 3'd6,
    REG_RECEIVER_ADDRESS = 3'd7
  } cfg_reg_t;

  // control field codes
  localparam logic [7:0] CODE_SET = 8'h03;
  localparam logic [7:0] CODE_UA  = 8'h07;
  localparam logic [7:0] CODE_RR0 = 8'h05;
  localparam logic [7:0] CODE_RR1 = 8'h85;
  localparam logic [7:0] CODE_I0  = 8'h00;
  localparam logic [7:0] CODE_I1  = 8'h40;

  // register reset values
  localparam logic [1:0] RST_FRAME_KIND       = 2'd0;
  localparam logic [7:0] RST_FLAG_BYTE        = 8'h7E;
  localparam logic [7:0] RST_ESCAPE_BYTE      = 8'h7D;
  localparam logic [7:0] RST_STUFF_MASK       = 8'h20;
  localparam logic [7:0] RST_SENDER_ADDRESS   = 8'h03;
  localparam logic [7:0] RST_RECEIVER_ADDRESS = 8'h01;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ADDRESS = 3'd1,
    ERR_CONTROL = 3'd2,
    ERR_HEADER  = 3'd3,
    ERR_CHECK   = 3'd4,
    ERR_ESCAPE  = 3'd5,
    ERR_LENGTH  = 3'd6
  } err_code_t;

  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_FLAG   = 3'd1,
    ST_ADDR   = 3'd2,
    ST_CTRL   = 3'd3,
    ST_HDR_OK = 3'd4,
    ST_DATA   = 3'd5,
    ST_ESC    = 3'd6
  } hunt_state_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic       role;
    logic       sequence_parity;
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] stuff_mask;
    logic [7:0] sender_address;
    logic [7:0] receiver_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic       frame_error;
    logic [2:0] error_kind;
  } res_item_t;

endpackage

// ===== rtl/lfr_stream_if.sv =====
`timescale 1ns / 1ps

interface lfr_stream_if
  import lfr_pkg::*;
#(
  parameter type payload_t = rx_item_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lfr_cfg.sv =====
`timescale 1ns / 1ps

module lfr_cfg
  import lfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_kind       <= RST_FRAME_KIND;
      cfg.role             <= 1'b0;
      cfg.sequence_parity  <= 1'b0;
      cfg.flag_byte        <= RST_FLAG_BYTE;
      cfg.escape_byte      <= RST_ESCAPE_BYTE;
      cfg.stuff_mask       <= RST_STUFF_MASK;
      cfg.sender_address   <= RST_SENDER_ADDRESS;
      cfg.receiver_address <= RST_RECEIVER_ADDRESS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_KIND:       cfg.frame_kind       <= cfg_data[1:0];
        REG_ROLE:             cfg.role             <= cfg_data[0];
        REG_SEQUENCE_PARITY:  cfg.sequence_parity  <= cfg_data[0];
        REG_FLAG_BYTE:        cfg.flag_byte        <= cfg_data;
        REG_ESCAPE_BYTE:      cfg.escape_byte      <= cfg_data;
        REG_STUFF_MASK:       cfg.stuff_mask       <= cfg_data;
        REG_SENDER_ADDRESS:   cfg.sender_address   <= cfg_data;
        REG_RECEIVER_ADDRESS: cfg.receiver_address <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lfr_core.sv =====
`timescale 1ns / 1ps

module lfr_core
  import lfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_item_t  res
);

  localparam int unsigned CountW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_PAYLOAD);
  localparam logic [CountW-1:0] CountMin = CountW'(2);

  hunt_state_t       state, state_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  logic [7:0]        payload_xor, payload_xor_next;
  logic [CountW-1:0] payload_count, payload_count_next;

  logic       data_mode;
  logic [7:0] want_addr, want_ctrl;
  logic       take;
  logic [7:0] take_val;
  logic       emit;
  logic       done;
  err_code_t  err;

  assign data_mode = cfg.frame_kind[1];

  always_comb begin
    if (data_mode) begin
      want_addr = cfg.sender_address;
      want_ctrl = cfg.sequence_parity ? CODE_I1 : CODE_I0;
    end else if (cfg.frame_kind[0]) begin
      want_addr = cfg.receiver_address;
      want_ctrl = cfg.sequence_parity ? CODE_RR0 : CODE_RR1;
    end else if (cfg.role) begin
      want_addr = cfg.receiver_address;
      want_ctrl = CODE_UA;
    end else begin
      want_addr = cfg.sender_address;
      want_ctrl = CODE_SET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      payload_xor   <= '0;
      payload_count <= '0;
    end else if (step) begin
      state         <= state_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      payload_xor   <= payload_xor_next;
      payload_count <= payload_count_next;
    end
  end

  always_comb begin
    state_next         = state;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    payload_xor_next   = payload_xor;
    payload_count_next = payload_count;
    take               = 1'b0;
    take_val           = rx_byte;
    emit               = 1'b0;
    done               = 1'b0;
    err                = ERR_NONE;

    case (state)
      ST_HUNT: begin
        if (rx_byte == cfg.flag_byte) state_next = ST_FLAG;
      end
      ST_FLAG: begin
        if (rx_byte == want_addr) state_next = ST_ADDR;
        else err = ERR_ADDRESS;
      end
      ST_ADDR: begin
        if (rx_byte == want_ctrl) state_next = ST_CTRL;
        else err = ERR_CONTROL;
      end
      ST_CTRL: begin
        if (rx_byte == (want_addr ^ want_ctrl)) begin
          held_byte_next     = '0;
          held_valid_next    = 1'b0;
          payload_xor_next   = '0;
          payload_count_next = '0;
          state_next         = data_mode ? ST_DATA : ST_HDR_OK;
        end else begin
          err = ERR_HEADER;
        end
      end
      ST_HDR_OK: begin
        if (rx_byte == cfg.flag_byte) done = 1'b1;
        else err = ERR_CHECK;
      end
      ST_DATA: begin
        if (!data_mode) begin
          // kind changed under a running frame: drop it quietly
          state_next         = ST_HUNT;
          held_byte_next     = '0;
          held_valid_next    = 1'b0;
          payload_xor_next   = '0;
          payload_count_next = '0;
        end else if (rx_byte == cfg.escape_byte) begin
          state_next = ST_ESC;
        end else if (rx_byte == cfg.flag_byte) begin
          if (payload_count < CountMin) err = ERR_LENGTH;
          else if (payload_xor != held_byte) err = ERR_CHECK;
          else done = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      ST_ESC: begin
        if (!data_mode) begin
          state_next         = ST_HUNT;
          held_byte_next     = '0;
          held_valid_next    = 1'b0;
          payload_xor_next   = '0;
          payload_count_next = '0;
        end else if (rx_byte == (cfg.flag_byte ^ cfg.stuff_mask)) begin
          state_next = ST_DATA;
          take       = 1'b1;
          take_val   = cfg.flag_byte;
        end else if (rx_byte == (cfg.escape_byte ^ cfg.stuff_mask)) begin
          state_next = ST_DATA;
          take       = 1'b1;
          take_val   = cfg.escape_byte;
        end else begin
          err = ERR_ESCAPE;
        end
      end
      default: begin
        state_next         = ST_HUNT;
        held_byte_next     = '0;
        held_valid_next    = 1'b0;
        payload_xor_next   = '0;
        payload_count_next = '0;
      end
    endcase

    // destuffed byte: the held one goes out, the new one is held back
    if (take) begin
      if (payload_count >= CountMax) begin
        err = ERR_LENGTH;
      end else begin
        payload_count_next = payload_count + CountW'(1);
        emit               = held_valid;
        if (held_valid) payload_xor_next = payload_xor ^ held_byte;
        held_byte_next     = take_val;
        held_valid_next    = 1'b1;
      end
    end

    if (err != ERR_NONE || done) begin
      state_next         = ST_HUNT;
      held_byte_next     = '0;
      held_valid_next    = 1'b0;
      payload_xor_next   = '0;
      payload_count_next = '0;
    end

    res.data_valid  = emit && (err == ERR_NONE);
    res.data_byte   = (emit && (err == ERR_NONE)) ? held_byte : 8'h00;
    res.frame_done  = done && (err == ERR_NONE);
    res.frame_error = (err != ERR_NONE);
    res.error_kind  = err;
  end

`ifndef SYNTHESIS
  a_hunt_quiet: assert property (@(posedge clk) disable iff (rst)
    step && state == ST_HUNT |-> !res.data_valid && !res.frame_done && !res.frame_error)
    else $error("result flagged while hunting for a flag");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    step && (res.frame_done || res.frame_error) |=> state == ST_HUNT && !held_valid)
    else $error("frame end did not return to hunting");

  a_emit_needs_held: assert property (@(posedge clk) disable iff (rst)
    step && res.data_valid |-> held_valid && (state == ST_DATA || state == ST_ESC))
    else $error("payload byte emitted without a held byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    step && res.data_valid |=> payload_count <= CountMax && payload_count >= CountMin)
    else $error("payload count out of range after emitting");
`endif

endmodule

// ===== rtl/link_frame_receiver.sv =====
// Link frame receiver: takes one received link byte per item on rx and returns exactly one
// result item per byte on tx. It hunts for flag, address, control and header check, then
// either a closing flag (connection or receive-ready frames) or, for information frames, a
// byte-stuffed payload, a check byte equal to the XOR of the payload, and a closing flag.
// Payload bytes leave one item late, so the check byte is never shown as data; frame_done or
// frame_error with error_kind marks the item that ends a frame. Throughput is one item per
// clock while tx is not stalled: each byte goes through an input register, a single pass
// of state update and destuffing, and a result register, so a result is offered on tx
// from the result register after its byte leaves the input register. The input register
// lets one more byte in while a result waits on tx. The user must write configuration
// through cfg_we, cfg_index and cfg_data only while the block holds no item, which it does
// not enforce; MAX_PAYLOAD bounds a frame's destuffed byte count, check byte included.
`timescale 1ns / 1ps

module link_frame_receiver
  import lfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lfr_stream_if.sink             rx,
  lfr_stream_if.source           tx
);

  cfg_t       cfg;
  res_item_t  res;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // result register
  logic       out_valid;
  res_item_t  out_item;

  // the held item moves on once the result register is free or being drained
  logic       advance;

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.payload.rx_byte;
    end
  end

  lfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // deframer state and destuffing, stepped once per item
  lfr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign tx.valid   = out_valid;
  assign tx.payload = out_item;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lfr_pkg::*;

  // small payload limit so that overflow shows up in ordinary frames
  localparam int unsigned PAYLOAD_LIMIT = 12;
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned PHASE_ITEMS   = 45;
  localparam int unsigned HOLD_CYCLES   = 80;    // long receiver hold-off

  // one row of the opening sequence: either a register write or a byte to send
  typedef struct packed {
    logic       reg_write;
    cfg_reg_t   reg_idx;    // only meaningful on register rows
    logic [7:0] value;      // register value or byte
    logic       typed;      // want is written out by hand
    res_item_t  want;
  } plan_row_t;

  typedef struct {
    rx_item_t  item;
    logic      typed;
    res_item_t want;
  } offer_t;

  localparam res_item_t QUIET       = '0;
  localparam res_item_t CLOSED      = '{1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE};
  localparam res_item_t BAD_ADDRESS = '{1'b0, 8'h00, 1'b0, 1'b1, ERR_ADDRESS};
  localparam res_item_t BAD_CONTROL = '{1'b0, 8'h00, 1'b0, 1'b1, ERR_CONTROL};
  localparam res_item_t BAD_HEADER  = '{1'b0, 8'h00, 1'b0, 1'b1, ERR_HEADER};
  localparam res_item_t BAD_TRAILER = '{1'b0, 8'h00, 1'b0, 1'b1, ERR_CHECK};
  localparam res_item_t BAD_LENGTH  = '{1'b0, 8'h00, 1'b0, 1'b1, ERR_LENGTH};

  // opening sequence under the reset settings: connection frame checks, then one
  // information frame with both escapes and one with nothing but a check byte
  localparam plan_row_t OPENING [0:31] = '{
    '{1'b0, REG_FRAME_KIND, 8'h00, 1'b1, QUIET},        // stray byte while hunting
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, BAD_ADDRESS},  // repeated flag
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'hFF, 1'b1, BAD_HEADER},
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h00, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'hFF, 1'b1, BAD_TRAILER},  // closing flag missing
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h07, 1'b1, BAD_CONTROL},  // UA where SET is due
    '{1'b1, REG_FRAME_KIND, 8'h02, 1'b0, QUIET},        // switch to information frames
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h00, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h7D, 1'b1, QUIET},        // escaped flag
    '{1'b0, REG_FRAME_KIND, 8'h5E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h7D, 1'b1, QUIET},        // escaped escape
    '{1'b0, REG_FRAME_KIND, 8'h5D, 1'b0, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b0, QUIET},        // check byte
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, CLOSED},
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h00, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h03, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'hFF, 1'b1, QUIET},
    '{1'b0, REG_FRAME_KIND, 8'h7E, 1'b1, BAD_LENGTH}    // check byte only, no payload
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lfr_stream_if #(.payload_t(rx_item_t))  rx_ch ();
  lfr_stream_if #(.payload_t(res_item_t)) tx_ch ();

  link_frame_receiver #(.MAX_PAYLOAD(PAYLOAD_LIMIT)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .tx       (tx_ch)
  );

  // bytes waiting to go out, and results still to come back
  offer_t      send_q[$];
  res_item_t   result_q[$];
  offer_t      on_wire;     // item currently offered on rx
  logic        rx_took;
  int unsigned fed;
  int unsigned faults;
  int unsigned quiet;
  int unsigned hold_asks;
  logic        calm;        // no idling on either side

  // deframer mirror: settings and per-frame state
  cfg_t        setup;
  hunt_state_t frame_phase;
  logic [7:0]  pending_byte;
  logic        pending_ok;
  logic [7:0]  payload_sum;
  int unsigned payload_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic info_mode();
    return setup.frame_kind[1];  // kind three behaves as an information frame
  endfunction

  function automatic logic [7:0] addr_due();
    if (info_mode()) return setup.sender_address;
    if (setup.frame_kind == 2'd1) return setup.receiver_address;
    return setup.role ? setup.receiver_address : setup.sender_address;
  endfunction

  function automatic logic [7:0] ctrl_due();
    if (info_mode()) return setup.sequence_parity ? CODE_I1 : CODE_I0;
    if (setup.frame_kind == 2'd1) return setup.sequence_parity ? CODE_RR0 : CODE_RR1;
    return setup.role ? CODE_UA : CODE_SET;
  endfunction

  function automatic void forget_payload();
    pending_byte = 8'h00;
    pending_ok   = 1'b0;
    payload_sum  = 8'h00;
    payload_len  = 0;
  endfunction

  // one destuffed byte into the frame; the previously held byte goes out
  function automatic err_code_t absorb(input logic [7:0] d, inout res_item_t r);
    if (payload_len >= PAYLOAD_LIMIT) return ERR_LENGTH;
    payload_len++;
    if (pending_ok) begin
      r.data_valid = 1'b1;
      r.data_byte  = pending_byte;
      payload_sum  = payload_sum ^ pending_byte;
    end
    pending_byte = d;
    pending_ok   = 1'b1;
    return ERR_NONE;
  endfunction

  // result of one received byte under the current settings
  function automatic res_item_t deframe_step(logic [7:0] b);
    res_item_t  r;
    err_code_t  e;
    logic       done;
    logic [7:0] a;
    logic [7:0] c;
    r    = '0;
    e    = ERR_NONE;
    done = 1'b0;
    a    = addr_due();
    c    = ctrl_due();
    case (frame_phase)
      ST_HUNT: begin
        if (b == setup.flag_byte) frame_phase = ST_FLAG;
      end
      ST_FLAG: begin
        if (b == a) frame_phase = ST_ADDR;
        else e = ERR_ADDRESS;
      end
      ST_ADDR: begin
        if (b == c) frame_phase = ST_CTRL;
        else e = ERR_CONTROL;
      end
      ST_CTRL: begin
        if (b == (a ^ c)) begin
          forget_payload();
          frame_phase = info_mode() ? ST_DATA : ST_HDR_OK;
        end else begin
          e = ERR_HEADER;
        end
      end
      ST_HDR_OK: begin
        if (b == setup.flag_byte) done = 1'b1;
        else e = ERR_CHECK;
      end
      ST_DATA: begin
        // kind switched away while in the payload: silent drop
        if (!info_mode()) begin
          frame_phase = ST_HUNT;
          forget_payload();
        end else if (b == setup.escape_byte) begin
          frame_phase = ST_ESC;
        end else if (b == setup.flag_byte) begin
          if (payload_len < 2) e = ERR_LENGTH;
          else if (payload_sum != pending_byte) e = ERR_CHECK;
          else done = 1'b1;
        end else begin
          e = absorb(b, r);
        end
      end
      ST_ESC: begin
        if (!info_mode()) begin
          frame_phase = ST_HUNT;
          forget_payload();
        end else if (b == (setup.flag_byte ^ setup.stuff_mask)) begin
          frame_phase = ST_DATA;
          e = absorb(setup.flag_byte, r);
        end else if (b == (setup.escape_byte ^ setup.stuff_mask)) begin
          frame_phase = ST_DATA;
          e = absorb(setup.escape_byte, r);
        end else begin
          e = ERR_ESCAPE;
        end
      end
      default: begin
        frame_phase = ST_HUNT;
        forget_payload();
      end
    endcase
    if (e != ERR_NONE) begin
      r.data_valid  = 1'b0;
      r.data_byte   = 8'h00;
      r.frame_error = 1'b1;
      r.error_kind  = e;
      frame_phase   = ST_HUNT;
      forget_payload();
    end else if (done) begin
      r.frame_done = 1'b1;
      frame_phase  = ST_HUNT;
      forget_payload();
    end
    return r;
  endfunction

  function automatic void push_item(logic [7:0] b, logic typed, res_item_t want);
    offer_t o;
    o.item.rx_byte = b;
    o.typed        = typed;
    o.want         = want;
    send_q.push_back(o);
    fed++;
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // one frame for the current settings, mostly well formed, sometimes broken or noise
  function automatic void add_frame();
    logic [7:0] burst[$];
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] xsum;
    logic [7:0] v;
    int         flaw;
    int         n;
    a    = addr_due();
    c    = ctrl_due();
    xsum = 8'h00;
    flaw = $urandom_range(99);
    if (flaw >= 95) begin
      n = $urandom_range(1, 4);
      repeat (n) burst.push_back(8'($urandom_range(255)));
    end else begin
      burst.push_back(setup.flag_byte);
      burst.push_back(a ^ ((flaw >= 70 && flaw < 75) ? any_nonzero() : 8'h00));
      burst.push_back(c ^ ((flaw >= 75 && flaw < 80) ? any_nonzero() : 8'h00));
      burst.push_back(a ^ c ^ ((flaw >= 80 && flaw < 85) ? any_nonzero() : 8'h00));
      if (!info_mode()) begin
        burst.push_back(setup.flag_byte ^ ((flaw >= 85 && flaw < 90) ? any_nonzero() : 8'h00));
      end else begin
        // mostly short payloads, now and then empty or around the limit
        case ($urandom_range(9))
          0:       n = 0;
          1:       n = PAYLOAD_LIMIT - 1 + $urandom_range(2);
          default: n = $urandom_range(1, 5);
        endcase
        for (int k = 0; k <= n; k++) begin
          if (k == n) begin
            d = xsum ^ ((flaw >= 85 && flaw < 90) ? any_nonzero() : 8'h00);
          end else begin
            case ($urandom_range(7))
              0:       d = setup.flag_byte;
              1:       d = setup.escape_byte;
              default: d = 8'($urandom_range(255));
            endcase
            xsum = xsum ^ d;
          end
          if (d == setup.flag_byte || d == setup.escape_byte) begin
            burst.push_back(setup.escape_byte);
            burst.push_back(d ^ setup.stuff_mask);
          end else begin
            burst.push_back(d);
          end
        end
        if (flaw >= 90) begin
          // escape followed by a byte that is neither stuffed code
          do v = 8'($urandom_range(255));
          while (v == (setup.flag_byte ^ setup.stuff_mask) ||
                 v == (setup.escape_byte ^ setup.stuff_mask));
          burst.push_back(setup.escape_byte);
          burst.push_back(v);
        end
        burst.push_back(setup.flag_byte);
      end
    end
    foreach (burst[i]) push_item(burst[i], 1'b0, QUIET);
  endfunction

  function automatic cfg_t phase_setup(int p);
    cfg_t s;
    s.frame_kind       = 2'($urandom_range(3));
    s.role             = 1'($urandom_range(1));
    s.sequence_parity  = 1'($urandom_range(1));
    s.flag_byte        = 8'($urandom_range(255));
    s.escape_byte      = 8'($urandom_range(255));
    s.stuff_mask       = 8'($urandom_range(255));
    s.sender_address   = 8'($urandom_range(255));
    s.receiver_address = 8'($urandom_range(255));
    case (p)
      0: s = '{2'd0, 1'b1, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
      1: s = '{2'd1, 1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
      2: s = '{2'd2, 1'b0, 1'b0, RST_FLAG_BYTE, RST_ESCAPE_BYTE, RST_STUFF_MASK,
               RST_SENDER_ADDRESS, RST_RECEIVER_ADDRESS};
      3: begin
        // flag and escape share one value
        s.frame_kind      = 2'd2;
        s.sequence_parity = 1'b1;
        s.escape_byte     = s.flag_byte;
      end
      4: s.frame_kind = 2'd3;
      5: s.frame_kind = 2'd2;
      default: ;
    endcase
    return s;
  endfunction

  task automatic set_reg(cfg_reg_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_KIND:       setup.frame_kind       = v[1:0];
      REG_ROLE:             setup.role             = v[0];
      REG_SEQUENCE_PARITY:  setup.sequence_parity  = v[0];
      REG_FLAG_BYTE:        setup.flag_byte        = v;
      REG_ESCAPE_BYTE:      setup.escape_byte      = v;
      REG_STUFF_MASK:       setup.stuff_mask       = v;
      REG_SENDER_ADDRESS:   setup.sender_address   = v;
      REG_RECEIVER_ADDRESS: setup.receiver_address = v;
      default: ;
    endcase
  endtask

  // every item in and every result back, then a short fixed wait
  task automatic settle();
    while (send_q.size() != 0 || rx_ch.valid || result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    faults++;
  endfunction

  // sender: takes the handshake at the rising edge, moves on at the falling edge
  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.payload = '0;
    rx_took       = 1'b0;
    forever begin
      @(posedge clk);
      rx_took = rx_ch.valid && rx_ch.ready;
      @(negedge clk);
      if (!rst && (!rx_ch.valid || rx_took)) begin
        if (send_q.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
          on_wire = send_q.pop_front();
          rx_ch.valid   <= 1'b1;
          rx_ch.payload <= on_wire.item;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        tx_ch.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen   = hold_asks;
        hold_left   = HOLD_CYCLES;
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // predict on every accepted byte, check every accepted result, watch for a hang
  initial begin
    res_item_t guess;
    res_item_t want;
    res_item_t got;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rx_ch.valid && rx_ch.ready) begin
          guess = deframe_step(rx_ch.payload.rx_byte);
          result_q.push_back(on_wire.typed ? on_wire.want : guess);
        end
        if (tx_ch.valid && tx_ch.ready) begin
          got = tx_ch.payload;
          if (result_q.size() == 0) begin
            $display("%0t: result %h with nothing awaited", $time, got);
            faults++;
          end else begin
            want = result_q.pop_front();
            if (got.data_valid !== want.data_valid)
              report_field("data_valid", want.data_valid, got.data_valid);
            if (got.data_byte !== want.data_byte)
              report_field("data_byte", want.data_byte, got.data_byte);
            if (got.frame_done !== want.frame_done)
              report_field("frame_done", want.frame_done, got.frame_done);
            if (got.frame_error !== want.frame_error)
              report_field("frame_error", want.frame_error, got.frame_error);
            if (got.error_kind !== want.error_kind)
              report_field("error_kind", want.error_kind, got.error_kind);
          end
        end
        if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, quiet);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    cfg_t        s;
    int          p;
    int unsigned mark;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_KIND;
    cfg_data  = 8'h00;
    calm      = 1'b0;
    hold_asks = 0;
    faults    = 0;
    quiet     = 0;
    fed       = 0;
    setup = '{RST_FRAME_KIND, 1'b0, 1'b0, RST_FLAG_BYTE, RST_ESCAPE_BYTE, RST_STUFF_MASK,
              RST_SENDER_ADDRESS, RST_RECEIVER_ADDRESS};
    frame_phase = ST_HUNT;
    forget_payload();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // opening sequence
    foreach (OPENING[i]) begin
      if (OPENING[i].reg_write) begin
        settle();
        set_reg(OPENING[i].reg_idx, OPENING[i].value);
      end else begin
        push_item(OPENING[i].value, OPENING[i].typed, OPENING[i].want);
      end
    end
    settle();

    // random phases, each under its own settings
    fed = 0;
    p   = 0;
    while (fed < RANDOM_ITEMS) begin
      s = phase_setup(p);
      set_reg(REG_FRAME_KIND, {6'd0, s.frame_kind});
      set_reg(REG_ROLE, {7'd0, s.role});
      set_reg(REG_SEQUENCE_PARITY, {7'd0, s.sequence_parity});
      set_reg(REG_FLAG_BYTE, s.flag_byte);
      set_reg(REG_ESCAPE_BYTE, s.escape_byte);
      set_reg(REG_STUFF_MASK, s.stuff_mask);
      set_reg(REG_SENDER_ADDRESS, s.sender_address);
      set_reg(REG_RECEIVER_ADDRESS, s.receiver_address);
      // a stretch with no idling, the first part of it under a long receiver hold-off
      calm = (p >= 1 && p <= 3);
      if (p == 1) hold_asks++;
      mark = fed;
      while (fed - mark < PHASE_ITEMS) add_frame();
      if (p == 5) begin
        // leave a frame inside its payload, sometimes right after an escape,
        // then switch to a supervisory kind so that the frame is dropped
        push_item(setup.flag_byte, 1'b0, QUIET);
        push_item(addr_due(), 1'b0, QUIET);
        push_item(ctrl_due(), 1'b0, QUIET);
        push_item(addr_due() ^ ctrl_due(), 1'b0, QUIET);
        push_item(8'($urandom_range(255)), 1'b0, QUIET);
        if ($urandom_range(1) != 0) push_item(setup.escape_byte, 1'b0, QUIET);
        settle();
        set_reg(REG_FRAME_KIND, 8'($urandom_range(1)));
        push_item(8'($urandom_range(255)), 1'b0, QUIET);
        repeat (4) add_frame();
      end
      settle();
      calm = 1'b0;
      p++;
    end

    settle();
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
